// ===== sv/ple_pkg.sv =====
// Shared types, codes and constants for the positional list engine.
package ple_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int OP_W         = 2;
    localparam int POS_W        = 11;
    localparam int VAL_W        = 32;
    localparam int ST_W         = 3;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DUMP   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4,
        ST_FOUND    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        VS_REQ  = 2'd0,
        VS_ZERO = 2'd1,
        VS_RAM  = 2'd2
    } t_vsel;

    typedef enum logic [1:0] {
        PS_REQ  = 2'd0,
        PS_ZERO = 2'd1,
        PS_IDX  = 2'd2
    } t_psel;

    typedef struct packed {
        logic    load;
        logic    idx_cnt;
        logic    idx_pos;
        logic    idx_zero;
        logic    idx_inc;
        logic    idx_dec;
        logic    rd_dn;
        logic    we;
        logic    wr_dn;
        logic    wsel_val;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cap_val;
        logic    emit;
        t_status status;
        t_vsel   vsel;
        t_psel   psel;
        logic    last;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic pos_zero;
        logic pos_gt_cnt1;
        logic pos_gt_cnt;
        logic cnt_zero;
        logic cnt_full;
        logic idx_ge_pos;
        logic idx_lt_cnt;
        logic idx_last;
        logic match;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/positional_list_engine_top.sv =====
// Top level of the positional list engine: ordered list with insert, delete, search, dump.
//
//  channel   | dir | handshake              | payload
//  request   | in  | i_s_tvalid / o_s_tready| i_s_tdata: op, position, value
//  result    | out | o_m_tvalid / i_m_tready| o_m_tdata: status, item_value, item_position
//            |     |                        | o_m_tlast: last
//
//  One request at a time; a single-port-read RAM of CAPACITY entries holds the list.
//  Insert moves the entries from the tail back to position up by one slot, then writes the value;
//  delete returns the removed entry, moving later ones down; search scans from entry 1; dump reads all.
//  Reset clears the count and the result valid flag; the RAM needs no clearing.
//  A stalled result holds the engine in the state that emits the next result until taken; a new request
//  is accepted while the last result still waits.
module positional_list_engine_top #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [ple_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // op[1:0], position[12:2], value[44:13]
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [ple_pkg::OUT_TDATA_W-1:0]    o_m_tdata,  // status[2:0], item_value[34:3], item_position[45:35]
    output logic                               o_m_tlast
);
    import ple_pkg::*;

    t_cmd                    w_cmd;
    t_sts                    w_sts;
    logic [ST_W-1:0]         w_status;
    logic signed [VAL_W-1:0] w_item_value;
    logic [POS_W-1:0]        w_item_position;

    ple_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    ple_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_op           (i_s_tdata[1:0]),
        .i_position     (i_s_tdata[12:2]),
        .i_value        (i_s_tdata[44:13]),
        .i_m_tready     (i_m_tready),
        .o_m_valid      (o_m_tvalid),
        .o_status       (w_status),
        .o_item_value   (w_item_value),
        .o_item_position(w_item_position),
        .o_last         (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, w_item_position, w_item_value, w_status};

endmodule

// ===== sv/ple_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ple_dp.sv =====
// Datapath: request registers, count, index, entry RAM and result register.
module ple_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ple_pkg::t_cmd                 i_cmd,
    output ple_pkg::t_sts                 o_sts,
    input  logic [ple_pkg::OP_W-1:0]      i_op,
    input  logic [ple_pkg::POS_W-1:0]     i_position,
    input  logic signed [ple_pkg::VAL_W-1:0] i_value,
    input  logic                          i_m_tready,
    output logic                          o_m_valid,
    output logic [ple_pkg::ST_W-1:0]      o_status,
    output logic signed [ple_pkg::VAL_W-1:0] o_item_value,
    output logic [ple_pkg::POS_W-1:0]     o_item_position,
    output logic                          o_last
);
    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_op                      r_op;
    logic [POS_W-1:0]         r_pos;
    logic signed [VAL_W-1:0]  r_val;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_idx;
    logic                     r_out_valid;
    t_status                  r_ost;
    logic signed [VAL_W-1:0]  r_oval;
    logic [POS_W-1:0]         r_opos;
    logic                     r_olast;

    logic [CW-1:0]            n_rd_idx;
    logic [CW-1:0]            n_wr_idx;
    logic [VAL_W-1:0]         n_rdata;
    logic [VAL_W-1:0]         n_wdata;
    logic signed [VAL_W-1:0]  n_oval;
    logic [POS_W-1:0]         n_opos;
    logic                     n_out_free;

    assign n_rd_idx   = i_cmd.rd_dn ? (r_idx - CW'(1)) : r_idx;
    assign n_wr_idx   = i_cmd.wr_dn ? (r_idx - CW'(1)) : r_idx;
    assign n_wdata    = i_cmd.wsel_val ? r_val : n_rdata;
    assign n_out_free = !r_out_valid || i_m_tready;

    ple_ram #(
        .WIDTH(VAL_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.we),
        .i_waddr(n_wr_idx[AW-1:0]),
        .i_wdata(n_wdata),
        .i_raddr(n_rd_idx[AW-1:0]),
        .o_rdata(n_rdata)
    );

    always_comb begin
        o_sts             = '0;
        o_sts.op          = r_op;
        o_sts.pos_zero    = (r_pos == '0);
        o_sts.pos_gt_cnt1 = ((POS_W+1)'(r_pos) > ((POS_W+1)'(r_count) + (POS_W+1)'(1)));
        o_sts.pos_gt_cnt  = ((POS_W+1)'(r_pos) > (POS_W+1)'(r_count));
        o_sts.cnt_zero    = (r_count == '0);
        o_sts.cnt_full    = (r_count == CW'(CAPACITY));
        o_sts.idx_ge_pos  = (POS_W'(r_idx) >= r_pos);
        o_sts.idx_lt_cnt  = (r_idx < r_count);
        o_sts.idx_last    = ((CW+1)'(r_idx) + (CW+1)'(1) == (CW+1)'(r_count));
        o_sts.match       = (n_rdata == r_val);
        o_sts.out_free    = n_out_free;
    end

    always_comb begin
        unique case (i_cmd.vsel)
            VS_REQ:  n_oval = r_val;
            VS_ZERO: n_oval = '0;
            VS_RAM:  n_oval = n_rdata;
            default: n_oval = '0;
        endcase
        unique case (i_cmd.psel)
            PS_REQ:  n_opos = r_pos;
            PS_ZERO: n_opos = '0;
            PS_IDX:  n_opos = POS_W'(r_idx) + POS_W'(1);
            default: n_opos = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_op);
            r_pos <= i_position;
            r_val <= i_value;
        end else if (i_cmd.cap_val) begin
            r_val <= n_rdata;
        end
        priority if (i_cmd.idx_cnt) begin
            r_idx <= r_count;
        end else if (i_cmd.idx_pos) begin
            r_idx <= CW'(r_pos - POS_W'(1));
        end else if (i_cmd.idx_zero) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - CW'(1);
        end else begin
            r_idx <= r_idx;
        end
        if (i_cmd.emit) begin
            r_ost   <= i_cmd.status;
            r_oval  <= n_oval;
            r_opos  <= n_opos;
            r_olast <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid       = r_out_valid;
    assign o_status        = r_ost;
    assign o_item_value    = r_oval;
    assign o_item_position = r_opos;
    assign o_last          = r_olast;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count beyond capacity");
    a_inc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> (r_count < CW'(CAPACITY)))
        else $error("insert into full list");
    a_dec_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> (r_count != '0))
        else $error("delete from empty list");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !i_cmd.emit)
        else $error("result overwritten while stalled");
`endif

endmodule

// ===== sv/ple_ctrl.sv =====
// Controller state machine that sequences each request over the datapath.
module ple_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  ple_pkg::t_sts i_sts,
    output ple_pkg::t_cmd o_cmd
);
    import ple_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DECODE   = 12'b0000_0000_0010,
        S_INS_CHK  = 12'b0000_0000_0100,
        S_INS_WR   = 12'b0000_0000_1000,
        S_DEL_RD   = 12'b0000_0001_0000,
        S_DEL_CAP  = 12'b0000_0010_0000,
        S_DEL_CHK  = 12'b0000_0100_0000,
        S_DEL_WR   = 12'b0000_1000_0000,
        S_SRCH_CHK = 12'b0001_0000_0000,
        S_SRCH_CMP = 12'b0010_0000_0000,
        S_DUMP_RD  = 12'b0100_0000_0000,
        S_DUMP_OUT = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.last = 1'b1;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_INSERT: begin
                        if (i_sts.pos_zero || i_sts.pos_gt_cnt1 || i_sts.cnt_full) begin
                            o_cmd.status = i_sts.cnt_full && !i_sts.pos_zero
                                && !i_sts.pos_gt_cnt1 ? ST_FULL : ST_BADPOS;
                            o_cmd.vsel   = VS_REQ;
                            o_cmd.psel   = PS_REQ;
                            if (i_sts.out_free) begin
                                o_cmd.emit = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            o_cmd.idx_cnt = 1'b1;
                            n_state       = S_INS_CHK;
                        end
                    end
                    OP_DELETE: begin
                        if (i_sts.cnt_zero || i_sts.pos_zero || i_sts.pos_gt_cnt) begin
                            o_cmd.status = i_sts.cnt_zero ? ST_EMPTY : ST_BADPOS;
                            o_cmd.vsel   = VS_ZERO;
                            o_cmd.psel   = PS_REQ;
                            if (i_sts.out_free) begin
                                o_cmd.emit = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            o_cmd.idx_pos = 1'b1;
                            n_state       = S_DEL_RD;
                        end
                    end
                    OP_SEARCH: begin
                        if (i_sts.cnt_zero) begin
                            o_cmd.status = ST_EMPTY;
                            o_cmd.vsel   = VS_REQ;
                            o_cmd.psel   = PS_ZERO;
                            if (i_sts.out_free) begin
                                o_cmd.emit = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            o_cmd.idx_zero = 1'b1;
                            n_state        = S_SRCH_CHK;
                        end
                    end
                    OP_DUMP: begin
                        if (i_sts.cnt_zero) begin
                            o_cmd.status = ST_EMPTY;
                            o_cmd.vsel   = VS_ZERO;
                            o_cmd.psel   = PS_ZERO;
                            if (i_sts.out_free) begin
                                o_cmd.emit = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            o_cmd.idx_zero = 1'b1;
                            n_state        = S_DUMP_RD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_INS_CHK: begin
                o_cmd.rd_dn = 1'b1;
                if (i_sts.idx_ge_pos) begin
                    n_state = S_INS_WR;
                end else if (i_sts.out_free) begin
                    o_cmd.we       = 1'b1;
                    o_cmd.wsel_val = 1'b1;
                    o_cmd.cnt_inc  = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.status   = ST_OK;
                    o_cmd.vsel     = VS_REQ;
                    o_cmd.psel     = PS_REQ;
                    n_state        = S_IDLE;
                end
            end
            S_INS_WR: begin
                o_cmd.we      = 1'b1;
                o_cmd.idx_dec = 1'b1;
                n_state       = S_INS_CHK;
            end
            S_DEL_RD: begin
                n_state = S_DEL_CAP;
            end
            S_DEL_CAP: begin
                o_cmd.cap_val = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                if (i_sts.idx_lt_cnt) begin
                    n_state = S_DEL_WR;
                end else if (i_sts.out_free) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.emit    = 1'b1;
                    o_cmd.status  = ST_OK;
                    o_cmd.vsel    = VS_REQ;
                    o_cmd.psel    = PS_REQ;
                    n_state       = S_IDLE;
                end
            end
            S_DEL_WR: begin
                o_cmd.we      = 1'b1;
                o_cmd.wr_dn   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_DEL_CHK;
            end
            S_SRCH_CHK: begin
                if (i_sts.idx_lt_cnt) begin
                    n_state = S_SRCH_CMP;
                end else begin
                    o_cmd.status = ST_NOTFOUND;
                    o_cmd.vsel   = VS_REQ;
                    o_cmd.psel   = PS_ZERO;
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_SRCH_CMP: begin
                if (i_sts.match) begin
                    o_cmd.status = ST_FOUND;
                    o_cmd.vsel   = VS_REQ;
                    o_cmd.psel   = PS_IDX;
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SRCH_CHK;
                end
            end
            S_DUMP_RD: begin
                n_state = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                o_cmd.status = ST_OK;
                o_cmd.vsel   = VS_RAM;
                o_cmd.psel   = PS_IDX;
                o_cmd.last   = i_sts.idx_last;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_DUMP_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("emit without free result slot");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DECODE))
        else $error("request not decoded after load");
    a_cnt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.cnt_inc && o_cmd.cnt_dec))
        else $error("count moved both ways");
`endif

endmodule

// ===== sim/list_check_pkg.sv =====
// Expected-result tracking and checking for the positional list engine test.
`timescale 1ns / 1ps
package list_check_pkg;
    import ple_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [31:0] item_value;
        logic [10:0] item_position;
        logic        last;
    } list_result_t;

    class list_scoreboard;
        logic [31:0]  shadow_entries [CAPACITY_DEF];
        int           shadow_count = 0;
        list_result_t pending_results [$];
        int           mismatches = 0;

        function void push_result(t_status st, logic [31:0] v, logic [10:0] p, logic l);
            list_result_t r;
            r.status        = st;
            r.item_value    = v;
            r.item_position = p;
            r.last          = l;
            pending_results.push_back(r);
        endfunction

        function void report(string msg);
            if (mismatches < 40) begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
            mismatches++;
        endfunction

        function void note_request(t_op op, logic [10:0] pos, logic [31:0] val);
            int p;
            int hit;
            logic [31:0] removed;
            p = int'(pos);
            case (op)
                OP_INSERT: begin
                    if (p < 1 || p > shadow_count + 1) begin
                        push_result(ST_BADPOS, val, pos, 1'b1);
                    end else if (shadow_count >= CAPACITY_DEF) begin
                        push_result(ST_FULL, val, pos, 1'b1);
                    end else begin
                        for (int i = shadow_count; i >= p; i--) begin
                            shadow_entries[i] = shadow_entries[i-1];
                        end
                        shadow_entries[p-1] = val;
                        shadow_count++;
                        push_result(ST_OK, val, pos, 1'b1);
                    end
                end
                OP_DELETE: begin
                    if (shadow_count == 0) begin
                        push_result(ST_EMPTY, 32'd0, pos, 1'b1);
                    end else if (p < 1 || p > shadow_count) begin
                        push_result(ST_BADPOS, 32'd0, pos, 1'b1);
                    end else begin
                        removed = shadow_entries[p-1];
                        for (int i = p; i < shadow_count; i++) begin
                            shadow_entries[i-1] = shadow_entries[i];
                        end
                        shadow_count--;
                        push_result(ST_OK, removed, pos, 1'b1);
                    end
                end
                OP_SEARCH: begin
                    if (shadow_count == 0) begin
                        push_result(ST_EMPTY, val, 11'd0, 1'b1);
                    end else begin
                        hit = 0;
                        for (int i = 0; i < shadow_count; i++) begin
                            if (hit == 0 && shadow_entries[i] == val) begin
                                hit = i + 1;
                            end
                        end
                        if (hit != 0) begin
                            push_result(ST_FOUND, val, 11'(hit), 1'b1);
                        end else begin
                            push_result(ST_NOTFOUND, val, 11'd0, 1'b1);
                        end
                    end
                end
                default: begin
                    if (shadow_count == 0) begin
                        push_result(ST_EMPTY, 32'd0, 11'd0, 1'b1);
                    end else begin
                        for (int i = 0; i < shadow_count; i++) begin
                            push_result(ST_OK, shadow_entries[i], 11'(i + 1),
                                        (i + 1 == shadow_count));
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(logic [47:0] tdata, logic tlast);
            list_result_t got;
            list_result_t want;
            got.status        = t_status'(tdata[2:0]);
            got.item_value    = tdata[34:3];
            got.item_position = tdata[45:35];
            got.last          = tlast;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result status %0d value %0d position %0d last %0d",
                                 got.status, $signed(got.item_value), got.item_position,
                                 got.last));
                return;
            end
            want = pending_results.pop_front();
            if (got != want) begin
                report($sformatf({"got status %0d value %0d position %0d last %0d, ",
                                  "want status %0d value %0d position %0d last %0d"},
                                 got.status, $signed(got.item_value), got.item_position,
                                 got.last, want.status, $signed(want.item_value),
                                 want.item_position, want.last));
            end
        endfunction
    endclass

endpackage

// ===== sim/positional_list_engine_top_test.sv =====
// Directed and randomized stream test of the positional list engine against a shadow list.
`timescale 1ns / 1ps
module positional_list_engine_top_test;
    import ple_pkg::*;
    import list_check_pkg::*;

    localparam int RANDOM_ITEMS = 360;
    localparam int IDLE_LIMIT   = 4000;

    typedef enum int {EP_GROW, EP_SHRINK, EP_MIXED, EP_NOISE} t_episode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // op[1:0], position[12:2], value[44:13]
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // status[2:0], item_value[34:3], item_position[45:35]
    logic                   o_m_tlast;

    list_scoreboard sb = new;
    int             sent_requests = 0;
    bit             sender_calm = 0;
    bit             sink_calm = 0;
    int             idle_cycles = 0;

    positional_list_engine_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [10:0] odd_position(int cnt);
        case ($urandom_range(0, 4))
            0:       return 11'd0;
            1:       return 11'(cnt + 1);
            2:       return 11'(cnt + 2);
            3:       return 11'd1024;
            default: return 11'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic logic [31:0] pick_value(t_op op, int cnt);
        logic [31:0] v;
        int          r;
        r = $urandom_range(0, 99);
        if (cnt > 0 && r < ((op == OP_SEARCH) ? 60 : 20)) begin
            return sb.shadow_entries[$urandom_range(0, cnt - 1)];
        end
        case ($urandom_range(0, 5))
            0: begin
                v = $urandom_range(0, 7);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            1:       v = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic send_request(input t_op op, input logic [10:0] pos, input logic [31:0] val);
        int gap;
        gap = (sender_calm || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, val, pos, op};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(op, pos, val);
        sent_requests++;
    endtask

    task automatic random_request(input t_episode mode);
        int          cnt;
        int          r;
        t_op         op;
        logic [10:0] pos;
        logic [31:0] val;
        cnt = sb.shadow_count;
        r   = $urandom_range(0, 99);
        case (mode)
            EP_GROW:   op = (r < 75) ? OP_INSERT : (r < 85) ? OP_SEARCH :
                            (r < 93) ? OP_DELETE : OP_DUMP;
            EP_SHRINK: op = (r < 70) ? OP_DELETE : (r < 82) ? OP_SEARCH :
                            (r < 92) ? OP_INSERT : OP_DUMP;
            default:   op = t_op'($urandom_range(0, 3));
        endcase
        if (mode == EP_NOISE || $urandom_range(0, 9) == 0) begin
            pos = odd_position(cnt);
        end else if (op == OP_DELETE) begin
            pos = (cnt == 0) ? 11'd1 : 11'($urandom_range(1, cnt));
        end else if (op == OP_INSERT) begin
            pos = 11'($urandom_range(1, cnt + 1));
        end else begin
            pos = 11'($urandom_range(0, 2047));
        end
        val = (mode == EP_NOISE) ? $urandom() : pick_value(op, cnt);
        send_request(op, pos, val);
    endtask

    task automatic run_directed();
        int          cnt;
        logic [10:0] pos;
        logic [31:0] val;
        send_request(OP_DUMP, 11'd0, 32'd0);
        send_request(OP_DELETE, 11'd1, 32'd0);
        send_request(OP_SEARCH, 11'd0, 32'h8000_0000);
        send_request(OP_INSERT, 11'd0, 32'd1);
        send_request(OP_INSERT, 11'd2, 32'd2);
        for (int k = 0; k < CAPACITY_DEF; k++) begin
            cnt = sb.shadow_count;
            pos = (k % 3 == 0) ? 11'd1 : (k % 3 == 1) ? 11'(cnt + 1) : 11'(cnt / 2 + 1);
            case (k)
                0:       val = 32'h7FFF_FFFF;
                1:       val = 32'h8000_0000;
                2:       val = 32'h0000_0000;
                3:       val = 32'hFFFF_FFFF;
                default: val = (k % 5 == 0) ? 32'd42 : $urandom();
            endcase
            send_request(OP_INSERT, pos, val);
        end
        send_request(OP_INSERT, 11'd5, 32'hA5A5_A5A5);
        send_request(OP_INSERT, 11'h7FF, 32'd0);
        send_request(OP_SEARCH, 11'd0, 32'd42);
        send_request(OP_SEARCH, 11'h7FF, 32'h1234_5678);
        send_request(OP_DUMP, 11'd0, 32'd0);
        send_request(OP_DELETE, 11'd0, 32'd0);
        send_request(OP_DELETE, 11'(sb.shadow_count + 1), 32'd0);
        send_request(OP_DELETE, 11'd1, 32'd0);
        send_request(OP_DELETE, 11'(sb.shadow_count), 32'd0);
    endtask

    task automatic run_random();
        t_episode mode;
        int       len;
        int       r;
        while (sent_requests < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            mode = (r < 3) ? EP_GROW : (r < 6) ? EP_SHRINK : (r < 9) ? EP_MIXED : EP_NOISE;
            len  = (mode == EP_GROW || mode == EP_SHRINK) ? $urandom_range(10, 40)
                                                          : $urandom_range(5, 20);
            sender_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len && sent_requests < RANDOM_ITEMS; k++) begin
                random_request(mode);
            end
        end
    endtask

    initial begin
        int ready_hold;
        int cycle;
        ready_hold = 0;
        cycle = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata, o_m_tlast);
            end
            cycle++;
            if (cycle % 256 == 0) begin
                sink_calm = ($urandom_range(0, 3) == 0);
            end
            if (ready_hold == 0) begin
                if (!sink_calm && $urandom_range(0, 2) == 0) begin
                    i_m_tready <= 1'b0;
                    ready_hold = idle_length();
                end else begin
                    i_m_tready <= 1'b1;
                    ready_hold = $urandom_range(1, 12);
                end
            end else begin
                ready_hold--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        i_s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ple_pkg.sv
sv/ple_ram.sv
sv/ple_dp.sv
sv/ple_ctrl.sv
sv/positional_list_engine_top.sv
sim/list_check_pkg.sv
sim/positional_list_engine_top_test.sv
